/* rtl/bda_pkg.sv */
// Package with the constants, control struct and state encoding of the decimal converter.
package bda_pkg;

  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned MAX_DIGITS = 10;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned CHAR_W     = 6;
  localparam int unsigned BIT_CNT_W  = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int unsigned DIG_CNT_W  = $clog2(MAX_DIGITS + 1);

  localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

  typedef struct packed {
    logic clear;
    logic conv;
    logic shift;
  } bda_ctrl_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SKIP = 4'b0100,
    ST_EMIT = 4'b1000
  } bda_state_e;

endpackage

/* rtl/bda_cell.sv */
// One decimal digit cell of the shift-and-add-three chain.
module bda_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bda_pkg::bda_ctrl_t            ctrl_i,
  input  logic                          carry_i,
  input  logic [bda_pkg::DIGIT_W-1:0]   digit_i,
  output logic                          carry_o,
  output logic [bda_pkg::DIGIT_W-1:0]   digit_o
);
  import bda_pkg::*;

  logic [DIGIT_W-1:0] digit_q, digit_d;
  logic [DIGIT_W-1:0] adj;

  always_comb begin
    adj = (digit_q >= DIGIT_W'(5)) ? digit_q + DIGIT_W'(3) : digit_q;
    carry_o = adj[DIGIT_W-1];
    digit_d = digit_q;
    if (ctrl_i.clear) begin
      digit_d = '0;
    end else if (ctrl_i.conv) begin
      digit_d = {adj[DIGIT_W-2:0], carry_i};
    end else if (ctrl_i.shift) begin
      digit_d = digit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= '0;
    end else begin
      digit_q <= digit_d;
    end
  end

  assign digit_o = digit_q;

endmodule

/* rtl/binary_to_decimal_ascii.sv */
// Top level of the binary to decimal ASCII converter.
// The input channel takes one unsigned value per item on value_i with in_valid_i, and
// in_stall_o stays high while an item is being converted or its digits are still leaving.
// The output channel gives one item per decimal digit, most significant first, on
// digit_char_o as an ASCII code, with last_digit_o high on the final digit. Leading
// zeros are suppressed and zero gives the single digit '0'.
// A row of ten digit cells runs the shift-and-add-three conversion, one input bit per
// cycle, over all 32 input bits. The same row then shifts its digits toward the top
// cell one per cycle, first discarding leading zeros, then handing each digit to the
// output register, in which phase it shifts only when the output register is free.
// When out_stall_i is high on a valid digit, the output register holds it and the row waits.
// The output register is separate, so the next value is accepted while the final
// digit of the previous one still waits. Reset empties the output register and
// returns the block to idle.
module binary_to_decimal_ascii (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [31:0]                    value_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [5:0]                     digit_char_o,
  output logic                           last_digit_o
);
  import bda_pkg::*;

  bda_state_e             state_q, state_d;
  logic [VALUE_BITS-1:0]  val_q, val_d;
  logic [BIT_CNT_W-1:0]   bit_cnt_q, bit_cnt_d;
  logic [DIG_CNT_W-1:0]   rem_q, rem_d;
  logic                   out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]      char_q, char_d;
  logic                   last_q, last_d;
  bda_ctrl_t              ctrl;
  logic                   in_accept;
  logic                   out_free;
  logic                   out_load;

  logic                   carry [MAX_DIGITS];
  logic [DIGIT_W-1:0]     digit [MAX_DIGITS];
  logic [DIGIT_W-1:0]     top_digit;

  for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
    bda_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .carry_i ((i == 0) ? val_q[VALUE_BITS-1] : carry[(i == 0) ? 0 : i-1]),
      .digit_i ((i == 0) ? '0 : digit[(i == 0) ? 0 : i-1]),
      .carry_o (carry[i]),
      .digit_o (digit[i])
    );
  end

  assign top_digit  = digit[MAX_DIGITS-1];
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = (state_q == ST_EMIT) && out_free;

  always_comb begin
    state_d     = state_q;
    val_d       = val_q;
    bit_cnt_d   = bit_cnt_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q && out_stall_i;
    char_d      = char_q;
    last_d      = last_q;
    ctrl        = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          val_d      = value_i[VALUE_BITS-1:0];
          bit_cnt_d  = '0;
          ctrl.clear = 1'b1;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        ctrl.conv = 1'b1;
        val_d     = val_q << 1;
        bit_cnt_d = bit_cnt_q + BIT_CNT_W'(1);
        if (bit_cnt_q == BIT_CNT_W'(VALUE_BITS - 1)) begin
          rem_d   = DIG_CNT_W'(MAX_DIGITS);
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (top_digit == '0 && rem_q > DIG_CNT_W'(1)) begin
          ctrl.shift = 1'b1;
          rem_d      = rem_q - DIG_CNT_W'(1);
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          char_d      = ASCII_ZERO + CHAR_W'(top_digit);
          last_d      = (rem_q == DIG_CNT_W'(1));
          ctrl.shift  = 1'b1;
          rem_d       = rem_q - DIG_CNT_W'(1);
          if (rem_q == DIG_CNT_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bit_cnt_q   <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bit_cnt_q   <= bit_cnt_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign digit_char_o = char_q;
  assign last_digit_o = last_q;

  a_accept_starts_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q == ST_CONV)
    else $error("Accepted item did not start conversion.");

  a_last_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && rem_q == DIG_CNT_W'(1)) |=> state_q == ST_IDLE && out_valid_q && last_q)
    else $error("Final digit did not return the block to idle.");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (char_q >= ASCII_ZERO && char_q <= ASCII_ZERO + CHAR_W'(9)))
    else $error("Output character is not a decimal digit.");

  a_rem_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SKIP || state_q == ST_EMIT) |-> rem_q != '0)
    else $error("Digit count ran out while digits remain.");

endmodule

/* bench/tb_binary_to_decimal_ascii.sv */
// Self-checking testbench for the binary to decimal ASCII converter with random flow control.
module tb_binary_to_decimal_ascii;
  timeunit 1ns;
  timeprecision 1ps;

  import bda_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;

  typedef struct {
    logic [CHAR_W-1:0] char_code;
    logic              last;
  } digit_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_stall_o;
  logic [31:0] value_i      = '0;
  logic        out_valid_o;
  logic        out_stall_i  = 1'b0;
  logic [5:0]  digit_char_o;
  logic        last_digit_o;

  digit_t pending_digits[$];
  int     error_count    = 0;
  int     cycle_count    = 0;
  int     burst_left     = 0;
  int     holdoff_cycles = 0;
  int     stall_pct      = 0;
  int     phase_left     = 0;

  binary_to_decimal_ascii i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .digit_char_o (digit_char_o),
    .last_digit_o (last_digit_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic void predict_digits(input logic [31:0] value);
    logic [3:0]        rev_digits[$];
    longint unsigned   rest;
    digit_t            entry;
    rest = longint'(value);
    do begin
      rev_digits.push_back(4'(rest % 10));
      rest = rest / 10;
    end while (rest != 0 && rev_digits.size() < MAX_DIGITS);
    for (int k = rev_digits.size() - 1; k >= 0; k--) begin
      entry.char_code = ASCII_ZERO + CHAR_W'(rev_digits[k]);
      entry.last      = (k == 0);
      pending_digits.push_back(entry);
    end
  endfunction

  task automatic send_value(input logic [31:0] value);
    if (burst_left == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20)) @(negedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    in_valid_i = 1'b1;
    value_i    = value;
    do @(posedge clk_i); while (in_stall_o);
    predict_digits(value);
    burst_left--;
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    digit_t exp_digit;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_digits.size() == 0) begin
        report_mismatch($sformatf("unexpected digit item char=%0d last=%0b",
                                  digit_char_o, last_digit_o));
      end else begin
        exp_digit = pending_digits.pop_front();
        if (digit_char_o !== exp_digit.char_code) begin
          report_mismatch($sformatf("digit_char got %0d expected %0d",
                                    digit_char_o, exp_digit.char_code));
        end
        if (last_digit_o !== exp_digit.last) begin
          report_mismatch($sformatf("last_digit got %0b expected %0b",
                                    last_digit_o, exp_digit.last));
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (phase_left == 0) begin
      phase_left = $urandom_range(16, 96);
      case ($urandom_range(0, 4))
        0, 1: stall_pct = 0;
        2: stall_pct = 20;
        3: stall_pct = 50;
        default: stall_pct = 80;
      endcase
    end
    phase_left--;
    if (holdoff_cycles > 0) begin
      holdoff_cycles--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic test_directed();
    logic [31:0] values[$];
    values = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd101, 32'd1000000000,
               32'd999999999, 32'd2147483647, 32'd2147483648, 32'd4000000000,
               32'd3999999999, 32'd4294967295, 32'd4294967294, 32'h55555555,
               32'hAAAAAAAA, 32'd1234567890, 32'd1000000, 32'd7, 32'd4294967290};
    foreach (values[i]) send_value(values[i]);
  endtask

  task automatic test_random(input int count);
    int unsigned     num_digits;
    longint unsigned lo_bound;
    longint unsigned hi_bound;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        send_value($urandom());
      end else begin
        num_digits = $urandom_range(1, MAX_DIGITS);
        lo_bound   = (num_digits == 1) ? 0 : 64'd10 ** (num_digits - 1);
        hi_bound   = 64'd10 ** num_digits - 1;
        if (hi_bound > 64'hFFFF_FFFF) hi_bound = 64'hFFFF_FFFF;
        send_value($urandom_range(32'(hi_bound), 32'(lo_bound)));
      end
    end
  endtask

  task automatic test_backpressure();
    repeat (2) begin
      @(negedge clk_i);
      holdoff_cycles = 400;
      burst_left     = 20;
      for (int i = 0; i < 10; i++) send_value($urandom());
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(150);
    test_backpressure();
    test_random(150);
    in_valid_i = 1'b0;
    while (pending_digits.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (pending_digits.size() != 0) begin
      report_mismatch($sformatf("%0d digit items never arrived", pending_digits.size()));
    end
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/bda_pkg.sv
rtl/bda_cell.sv
rtl/binary_to_decimal_ascii.sv
bench/tb_binary_to_decimal_ascii.sv
